/* rtl/rtm_pkg.sv */
// ----------------------------------------------------------------------------
// rtm_pkg
// Types and constants shared by the IPv4 route table match core.
// ----------------------------------------------------------------------------
`default_nettype none

package rtm_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int SLOT_W  = 4;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_MATCHED   = 3'd3,
    ST_NO_ROUTE  = 3'd4
  } rtm_status_t;

  typedef enum logic {
    ACT_ADD   = 1'b0,
    ACT_MATCH = 1'b1
  } rtm_action_t;

  typedef struct packed {
    logic        action;
    logic [31:0] address;
    logic [31:0] mask;
    logic [31:0] next_hop;
  } rtm_in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [31:0]       gateway_out;
    logic [SLOT_W-1:0] slot;
  } rtm_out_t;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gateway;
  } rtm_route_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    rtm_route_t       data;
  } rtm_wr_t;

endpackage

`default_nettype wire

/* rtl/rtm_route_mem.sv */
// ----------------------------------------------------------------------------
// rtm_route_mem
// Route store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rtm_route_mem
  import rtm_pkg::*;
(
  input  wire logic             clk,
  input  wire rtm_wr_t          wr,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output rtm_route_t            rd_data
);

  rtm_route_t route_mem_r [ENTRIES];
  rtm_route_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      route_mem_r[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= route_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/ipv4_route_table_match_core.sv */
// ----------------------------------------------------------------------------
// ipv4_route_table_match_core
// Route table with add and newest-first match, scanned one entry a cycle.
// ----------------------------------------------------------------------------
// The result strobe follows the scan of the n stored routes; a hit ends the
//   scan early.
// A transaction holds the core busy for its whole scan, paced by the single
//   read port of the route store, one entry read per cycle.
// A new start is taken in the cycle the result strobe is shown.
// Reset clears the route count and control state; the store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_route_table_match_core
  import rtm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire rtm_in_t in_data,
  output logic         busy,
  output logic         out_valid,
  output rtm_out_t     out_data
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t             state_r,    state_nxt;
  logic [CNT_W-1:0]   count_r,    count_nxt;
  logic [CNT_W-1:0]   left_r,     left_nxt;
  logic [IDX_W-1:0]   iss_idx_r,  iss_idx_nxt;
  logic               pend_r,     pend_nxt;
  logic [IDX_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  rtm_out_t           out_data_r, out_data_nxt;

  logic               act_r;
  logic [31:0]        addr_r;
  logic [31:0]        mask_r;
  logic [31:0]        gw_r;

  rtm_wr_t            mem_wr;
  logic               mem_rd_en;
  logic [IDX_W-1:0]   mem_rd_addr;
  rtm_route_t         mem_rd_data;

  logic               accept;
  logic               hit;
  logic [CNT_W-1:0]   count_dec;
  logic [IDX_W+SLOT_W-1:0] pend_slot_w;
  logic [IDX_W+SLOT_W-1:0] add_slot_w;

  rtm_route_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign accept    = start && (state_r == S_IDLE);
  assign count_dec = count_r - CNT_W'(1);

  assign pend_slot_w = {{SLOT_W{1'b0}}, pend_idx_r};
  assign add_slot_w  = {{SLOT_W{1'b0}}, count_r[IDX_W-1:0]};

  always_comb begin
    if (act_r == ACT_MATCH) begin
      hit = pend_r && ((addr_r & mem_rd_data.mask) == mem_rd_data.dest);
    end else begin
      hit = pend_r && (mem_rd_data.dest == addr_r) && (mem_rd_data.mask == mask_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    left_nxt      = left_r;
    iss_idx_nxt   = iss_idx_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = iss_idx_r;
    mem_wr.en     = 1'b0;
    mem_wr.addr   = count_r[IDX_W-1:0];
    mem_wr.data   = '{dest: addr_r, mask: mask_r, gateway: gw_r};

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
          left_nxt  = count_r;
          if (in_data.action == ACT_MATCH) begin
            iss_idx_nxt = count_dec[IDX_W-1:0];
          end else begin
            iss_idx_nxt = '0;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (act_r == ACT_MATCH) begin
            out_data_nxt.status      = ST_MATCHED;
            out_data_nxt.gateway_out = mem_rd_data.gateway;
            out_data_nxt.slot        = pend_slot_w[SLOT_W-1:0];
          end else begin
            out_data_nxt.status      = ST_DUPLICATE;
            out_data_nxt.gateway_out = '0;
            out_data_nxt.slot        = '0;
          end
        end else if (left_r == '0) begin
          state_nxt                = S_IDLE;
          out_valid_nxt            = 1'b1;
          out_data_nxt.gateway_out = '0;
          out_data_nxt.slot        = '0;
          if (act_r == ACT_MATCH) begin
            out_data_nxt.status = ST_NO_ROUTE;
          end else if (count_r == CNT_W'(ENTRIES)) begin
            out_data_nxt.status = ST_FULL;
          end else begin
            mem_wr.en           = 1'b1;
            count_nxt           = count_r + CNT_W'(1);
            out_data_nxt.status = ST_ADDED;
            out_data_nxt.slot   = add_slot_w[SLOT_W-1:0];
          end
        end else begin
          mem_rd_en    = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = iss_idx_r;
          left_nxt     = left_r - CNT_W'(1);
          if (act_r == ACT_MATCH) begin
            iss_idx_nxt = iss_idx_r - IDX_W'(1);
          end else begin
            iss_idx_nxt = iss_idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      left_r      <= '0;
      iss_idx_r   <= '0;
      pend_r      <= 1'b0;
      pend_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      iss_idx_r   <= iss_idx_nxt;
      pend_r      <= pend_nxt;
      pend_idx_r  <= pend_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  // operands of the transaction in flight; add keeps the masked destination
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_data.action;
      addr_r <= (in_data.action == ACT_MATCH) ? in_data.address
                                              : (in_data.address & in_data.mask);
      mask_r <= in_data.mask;
      gw_r   <= in_data.next_hop;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* tb/sv/tb_ipv4_route_table_match_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ipv4_route_table_match_core
// Self-checking bench for the IPv4 route table add and newest-first match.
// A fixed table of requests covers reset, extremes and duplicates. Random
// traffic then fills the table slowly, so lookups run at every fill level.
// A default route goes in last, followed by full-table and duplicate-on-full
// adds. A shadow copy of the table predicts each response not pinned by its
// row, and each response is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------

module tb_ipv4_route_table_match_core;
  import rtm_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int FILL_SPACING = 70;
  localparam int DEFAULT_AT   = 1100;
  localparam int DRAIN_EVERY  = 150;
  localparam int TAIL_CYCLES  = 40;
  localparam int IDLE_LIMIT   = 2000;

  typedef struct {
    rtm_in_t  item;
    bit       pinned;
    rtm_out_t want;
  } route_row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  rtm_in_t  in_data;
  logic     busy;
  logic     out_valid;
  rtm_out_t out_data;

  rtm_route_t route_tbl [ENTRIES];
  int         route_count;
  rtm_out_t   pending_results [$];
  route_row_t directed_rows [$];
  int         mismatches;

  ipv4_route_table_match_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Shadow table: add appends unless duplicate or full, match scans newest first.
  function automatic rtm_out_t route_table_step(rtm_in_t req);
    rtm_out_t    res;
    logic [31:0] dest;
    int          i;
    bit          dup;
    res = '0;
    if (req.action == ACT_ADD) begin
      dest = req.address & req.mask;
      dup  = 1'b0;
      for (i = 0; i < route_count; i++) begin
        if (route_tbl[i].dest == dest && route_tbl[i].mask == req.mask) dup = 1'b1;
      end
      if (dup) begin
        res.status = ST_DUPLICATE;
      end else if (route_count >= ENTRIES) begin
        res.status = ST_FULL;
      end else begin
        route_tbl[route_count].dest    = dest;
        route_tbl[route_count].mask    = req.mask;
        route_tbl[route_count].gateway = req.next_hop;
        res.status = ST_ADDED;
        res.slot   = SLOT_W'(route_count);
        route_count++;
      end
    end else begin
      res.status = ST_NO_ROUTE;
      for (i = route_count - 1; i >= 0; i--) begin
        if (res.status == ST_NO_ROUTE &&
            (req.address & route_tbl[i].mask) == route_tbl[i].dest) begin
          res.status      = ST_MATCHED;
          res.gateway_out = route_tbl[i].gateway;
          res.slot        = SLOT_W'(i);
        end
      end
    end
    return res;
  endfunction

  task automatic add_row(input logic act, input logic [31:0] addr, input logic [31:0] msk,
                         input logic [31:0] hop, input bit pinned,
                         input rtm_status_t st, input logic [31:0] gw,
                         input logic [SLOT_W-1:0] sl);
    route_row_t row;
    row.item.action      = act;
    row.item.address     = addr;
    row.item.mask        = msk;
    row.item.next_hop    = hop;
    row.pinned           = pinned;
    row.want.status      = st;
    row.want.gateway_out = gw;
    row.want.slot        = sl;
    directed_rows.push_back(row);
  endtask

  // One transaction: optional gap, then hold start until busy is seen low.
  task automatic issue_request(input rtm_in_t req, input bit pinned, input rtm_out_t want,
                               input int gap);
    rtm_out_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    predicted = route_table_step(req);
    pending_results.push_back(pinned ? want : predicted);
  endtask

  function automatic logic [31:0] inside_prefix(int idx);
    return route_tbl[idx].dest | ($urandom & ~route_tbl[idx].mask);
  endfunction

  always @(posedge clk) begin : result_check
    rtm_out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] unexpected response: status %0d gw %h slot %0d", $time,
                   out_data.status, out_data.gateway_out, out_data.slot);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.gateway_out !== want.gateway_out ||
            out_data.slot !== want.slot) begin
          if (mismatches < 10)
            $display("[%0t] mismatch: exp status %0d gw %h slot %0d, got status %0d gw %h slot %0d",
                     $time, want.status, want.gateway_out, want.slot,
                     out_data.status, out_data.gateway_out, out_data.slot);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid) idle = 0;
      else idle++;
    end
    $display("ipv4_route_table_match_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    rtm_in_t     req;
    rtm_out_t    none;
    int          k;
    int          r;
    int          idx;
    int          b;
    int          plen;
    bit          burst;
    logic [31:0] m;
    route_count = 0;
    mismatches  = 0;
    none        = '0;
    burst       = 1'b0;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;

    add_row(ACT_MATCH, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, ST_NO_ROUTE, 0, 0);
    add_row(ACT_MATCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_NO_ROUTE, 0, 0);
    add_row(ACT_ADD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_ADDED, 0, 0);
    add_row(ACT_ADD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1, ST_DUPLICATE, 0, 0);
    add_row(ACT_MATCH, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1, ST_MATCHED,
            32'hFFFF_FFFF, 0);
    add_row(ACT_MATCH, 32'hFFFF_FFFE, 32'h0000_0000, 32'h0000_0000, 1, ST_NO_ROUTE, 0, 0);
    add_row(ACT_MATCH, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1, ST_NO_ROUTE, 0, 0);
    add_row(ACT_ADD,   32'h0A00_00FF, 32'hFF00_0000, 32'h0A00_00FE, 0, ST_ADDED, 0, 0);
    add_row(ACT_ADD,   32'h0A55_AA01, 32'hFF00_0000, 32'h1234_5678, 1, ST_DUPLICATE, 0, 0);
    add_row(ACT_ADD,   32'h0A00_0000, 32'hFFFF_0000, 32'hC0A8_0001, 0, ST_ADDED, 0, 0);
    add_row(ACT_MATCH, 32'h0A00_0005, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, ST_MATCHED, 0, 0);
    add_row(ACT_MATCH, 32'h0A01_0005, 32'h0000_0000, 32'h0000_0000, 0, ST_MATCHED, 0, 0);
    add_row(ACT_MATCH, 32'h0B00_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 0, ST_NO_ROUTE, 0, 0);
    add_row(ACT_ADD,   32'h0A00_1234, 32'hFFFF_0000, 32'h0000_0000, 1, ST_DUPLICATE, 0, 0);
    // non-contiguous netmask
    add_row(ACT_ADD,   32'h5555_5555, 32'hAAAA_AAAA, 32'h5A5A_5A5A, 0, ST_ADDED, 0, 0);
    add_row(ACT_MATCH, 32'h5555_5555, 32'h0000_0000, 32'h0000_0000, 0, ST_MATCHED, 0, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      issue_request(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].want,
                    $urandom_range(0, 12));

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 64 == 0) burst = ($urandom_range(0, 2) == 0);
      if (k % DRAIN_EVERY == DRAIN_EVERY - 1) begin
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      req.action   = ACT_MATCH;
      req.address  = $urandom;
      req.mask     = $urandom;
      req.next_hop = $urandom;
      r   = $urandom_range(0, 99);
      idx = $urandom_range(0, route_count - 1);
      if (route_count < ENTRIES - 1 && route_count * FILL_SPACING < k) begin
        req.action = ACT_ADD;
        if ($urandom_range(0, 3) == 0) begin
          m = $urandom;
          if (m == 0) m = 32'h1;
        end else begin
          plen = $urandom_range(8, 32);
          m    = 32'hFFFF_FFFF << (32 - plen);
        end
        req.mask = m;
      end else if (route_count == ENTRIES - 1 && k >= DEFAULT_AT) begin
        // default route goes in last so it cannot shadow the earlier lookups
        req.action = ACT_ADD;
        req.mask   = '0;
      end else if (r < 12) begin
        req.action  = ACT_ADD;
        req.mask    = route_tbl[idx].mask;
        req.address = inside_prefix(idx);
      end else if (r < 20) begin
        if (route_count == ENTRIES) req.action = ACT_ADD;
      end else if (r < 55) begin
        req.address = inside_prefix(idx);
      end else if (r < 80) begin
        req.address = inside_prefix(idx);
        m = route_tbl[idx].mask;
        if (m != 0) begin
          b = $urandom_range(0, 31);
          while (!m[b]) b = $urandom_range(0, 31);
          req.address[b] = ~req.address[b];
        end
      end
      issue_request(req, 1'b0, none, burst ? 0 : $urandom_range(0, 12));
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("ipv4_route_table_match_core regression: pass");
    else
      $display("ipv4_route_table_match_core regression: fail");
    $finish;
  end

endmodule
